[src/urgency_round_robin_stream_scheduler_top_macros.svh]
// Assertion helpers for the stream scheduler.
`ifndef URGENCY_ROUND_ROBIN_STREAM_SCHEDULER_TOP_MACROS_SVH
`define URGENCY_ROUND_ROBIN_STREAM_SCHEDULER_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define URRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define URRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/urrs_pkg.sv]
package urrs_pkg;

    localparam int MAX_STREAMS    = 64;
    localparam int URGENCY_LEVELS = 8;
    localparam int IDX_W          = $clog2(MAX_STREAMS);
    localparam int CNT_W          = $clog2(MAX_STREAMS + 1);
    localparam int ID_W           = 62;

    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_UPDATE   = 3'd1;
    localparam logic [2:0] REQ_REMOVE   = 3'd2;
    localparam logic [2:0] REQ_READY    = 3'd3;
    localparam logic [2:0] REQ_NOTREADY = 3'd4;
    localparam logic [2:0] REQ_SELECT   = 3'd5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic [2:0]      req_type;
        logic [ID_W-1:0] sid;
        logic [2:0]      urgency;
        logic            incremental;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] selected_id;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, clear scan results
        logic scan_clr;  // clear scan accumulators, reset index
        logic scan_step; // read one entry and advance
        logic do_write;  // apply add/update/remove/mark
        logic sel_next;  // move to next urgency level
        logic sel_commit;
        logic rsp_load;
        logic [1:0] rsp_status;
        logic rsp_use_sel;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       id_zero;
        logic       scan_last;
        logic       found;
        logic       free_found;
        logic       lvl_any;
        logic       lvl_last;
    } sts_t;

endpackage

[src/urrs_datapath.sv]
module urrs_datapath
    import urrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  ctl_t ctl,
    output sts_t sts,
    output rsp_t rsp
);

    // table storage
    logic [MAX_STREAMS-1:0] valid_reg;
    logic [MAX_STREAMS-1:0] ready_reg;
    logic [ID_W-1:0]        id_mem  [MAX_STREAMS];
    logic [2:0]             urg_mem [MAX_STREAMS];
    logic                   inc_mem [MAX_STREAMS];
    logic [ID_W-1:0]        last_reg [URGENCY_LEVELS];

    // captured request and scan state
    req_t             req_reg;
    logic [2:0]       urg_c;
    logic [CNT_W-1:0] idx_reg;
    logic [2:0]       lvl_reg;
    logic             found_reg, free_found_reg;
    logic [IDX_W-1:0] hit_reg, free_reg;
    logic [2:0]       hit_u_reg;
    logic             any_reg, inc_reg, after_f_reg;
    logic [ID_W-1:0]  small_reg, after_reg;
    rsp_t             rsp_reg;

    // registered entry read of the read index, with that index kept in pix_reg
    logic [IDX_W-1:0] ix, pix_reg;
    logic             chk_reg;
    logic [ID_W-1:0]  e_id_reg;
    logic             e_v_reg, e_r_reg, e_inc_reg;
    logic [2:0]       e_u_reg;
    logic             e_hit, e_match, e_after;
    logic [ID_W-1:0]  sel_id;

    assign ix      = idx_reg[IDX_W-1:0];
    assign e_hit   = e_v_reg && (e_id_reg == req_reg.sid);
    assign e_match = e_v_reg && e_r_reg && (e_u_reg == lvl_reg);
    assign e_after = (e_id_reg > last_reg[lvl_reg]) && (!after_f_reg || e_id_reg < after_reg);
    assign urg_c = (req_reg.urgency >= 3'(URGENCY_LEVELS - 1)) ?
                   3'(URGENCY_LEVELS - 1) : req_reg.urgency;
    assign sel_id = (inc_reg && after_f_reg) ? after_reg : small_reg;

    // scan state, urgency level and match flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            lvl_reg        <= '0;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            inc_reg        <= 1'b0;
            after_f_reg    <= 1'b0;
        end
        else
        begin
            chk_reg <= ctl.scan_step;
            if (ctl.load)
            begin
                lvl_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (ctl.sel_next)
            begin
                lvl_reg <= lvl_reg + 3'd1;
            end
            if (ctl.scan_clr || ctl.load)
            begin
                idx_reg     <= '0;
                any_reg     <= 1'b0;
                inc_reg     <= 1'b0;
                after_f_reg <= 1'b0;
            end
            else
            begin
                if (ctl.scan_step)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (chk_reg)
                begin
                    if (e_hit && !found_reg)
                        found_reg <= 1'b1;
                    if (!e_v_reg && !free_found_reg)
                        free_found_reg <= 1'b1;
                    if (e_match)
                    begin
                        any_reg <= 1'b1;
                        if (e_inc_reg)
                            inc_reg <= 1'b1;
                        if (e_after)
                            after_f_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // scan payload, request capture and response register
    always_ff @(posedge clk)
    begin
        pix_reg <= ix;
        e_v_reg <= valid_reg[ix];
        e_r_reg <= ready_reg[ix];
        if (ctl.load)
            req_reg <= req;
        if (chk_reg)
        begin
            if (e_hit && !found_reg)
            begin
                hit_reg   <= pix_reg;
                hit_u_reg <= e_u_reg;
            end
            if (!e_v_reg && !free_found_reg)
                free_reg <= pix_reg;
            if (e_match)
            begin
                if (!any_reg || e_id_reg < small_reg)
                    small_reg <= e_id_reg;
                if (e_after)
                    after_reg <= e_id_reg;
            end
        end
        if (ctl.rsp_load)
        begin
            rsp_reg.status      <= ctl.rsp_status;
            rsp_reg.selected_id <= ctl.rsp_use_sel ? sel_id : '0;
        end
    end

    // flag arrays and round-robin pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ready_reg <= '0;
            for (int l = 0; l < URGENCY_LEVELS; l++)
                last_reg[l] <= '0;
        end
        else
        begin
            if (ctl.do_write)
            begin
                case (req_reg.req_type)
                    REQ_ADD, REQ_UPDATE:
                    begin
                        if (!found_reg)
                        begin
                            valid_reg[free_reg] <= 1'b1;
                            ready_reg[free_reg] <= 1'b0;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        // urgency captured during the lookup pass
                        valid_reg[hit_reg] <= 1'b0;
                        ready_reg[hit_reg] <= 1'b0;
                        if (last_reg[hit_u_reg] == req_reg.sid)
                            last_reg[hit_u_reg] <= '0;
                    end
                    REQ_READY:    ready_reg[hit_reg] <= 1'b1;
                    REQ_NOTREADY: ready_reg[hit_reg] <= 1'b0;
                    default: ;
                endcase
            end
            if (ctl.sel_commit && inc_reg)
                last_reg[lvl_reg] <= sel_id;
        end
    end

    // entry fields: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.do_write && (req_reg.req_type inside {REQ_ADD, REQ_UPDATE}))
        begin
            if (found_reg)
            begin
                urg_mem[hit_reg] <= urg_c;
                inc_mem[hit_reg] <= req_reg.incremental;
            end
            else
            begin
                id_mem[free_reg]  <= req_reg.sid;
                urg_mem[free_reg] <= urg_c;
                inc_mem[free_reg] <= req_reg.incremental;
            end
        end
        e_id_reg  <= id_mem[ix];
        e_u_reg   <= urg_mem[ix];
        e_inc_reg <= inc_mem[ix];
    end

    assign sts.req_type   = req_reg.req_type;
    assign sts.id_zero    = (req_reg.sid == '0);
    assign sts.scan_last  = (idx_reg == CNT_W'(MAX_STREAMS - 1));
    assign sts.found      = found_reg;
    assign sts.free_found = free_found_reg;
    assign sts.lvl_any    = any_reg;
    assign sts.lvl_last   = (lvl_reg == 3'(URGENCY_LEVELS - 1));
    assign rsp            = rsp_reg;

endmodule

[src/urrs_ctrl.sv]
module urrs_ctrl
    import urrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SSCAN = 3'd3;
    localparam logic [2:0] S_SDEC  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       fire;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign fire      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.req_type == REQ_SELECT)
                begin
                    state_next = S_SSCAN;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    if (sts.scan_last)
                        state_next = S_FLUSH;
                end
            end
            // last entry read is still being evaluated
            S_FLUSH:
            begin
                if (sts.req_type == REQ_SELECT)
                    state_next = S_SDEC;
                else
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                ctl.rsp_load   = 1'b1;
                ctl.rsp_status = ST_IGNORED;
                state_next     = S_OUT;
                case (sts.req_type)
                    REQ_ADD, REQ_UPDATE:
                    begin
                        if (sts.found && sts.req_type == REQ_UPDATE)
                        begin
                            ctl.do_write   = 1'b1;
                            ctl.rsp_status = ST_DONE;
                        end
                        else if (sts.id_zero || sts.found)
                            ctl.rsp_status = ST_IGNORED;
                        else if (!sts.free_found)
                            ctl.rsp_status = ST_FULL;
                        else
                        begin
                            ctl.do_write   = 1'b1;
                            ctl.rsp_status = ST_DONE;
                        end
                    end
                    REQ_REMOVE, REQ_READY, REQ_NOTREADY:
                    begin
                        if (sts.found)
                        begin
                            ctl.do_write   = 1'b1;
                            ctl.rsp_status = ST_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            S_SSCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_FLUSH;
            end
            S_SDEC:
            begin
                if (sts.lvl_any)
                begin
                    ctl.sel_commit  = 1'b1;
                    ctl.rsp_load    = 1'b1;
                    ctl.rsp_status  = ST_DONE;
                    ctl.rsp_use_sel = 1'b1;
                    state_next      = S_OUT;
                end
                else if (sts.lvl_last)
                begin
                    ctl.rsp_load   = 1'b1;
                    ctl.rsp_status = ST_NONE;
                    state_next     = S_OUT;
                end
                else
                begin
                    ctl.sel_next = 1'b1;
                    ctl.scan_clr = 1'b1;
                    state_next   = S_SSCAN;
                end
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/urgency_round_robin_stream_scheduler_top.sv]
// Channel | Signals                        | Beat
// in      | in_valid, in_ready, in_data    | one request (req_t)
// out     | out_valid, out_ready, out_data | one response (rsp_t)
// Non-select: the response follows the input beat through a 64-entry pass, the
// registered entry read, a decide state and the output register.
// Select: a 64-entry pass and a decide state per urgency level scanned (up to 8 levels), then the output register.
// The table scan runs through the single registered entry read port.
// Reset clears valid/ready bits and round-robin pointers at once; no sweep.
// A new request can be taken from the cycle after the response beat has been accepted.
module urgency_round_robin_stream_scheduler_top
    import urrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    ctl_t ctl;
    sts_t sts;

    urrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    urrs_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (out_data)
    );

endmodule

[src/urrs_checker.sv]
`include "urgency_round_robin_stream_scheduler_top_macros.svh"

module urrs_checker
    import urrs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input rsp_t out_data,
    input logic out_valid,
    input logic out_ready
);

    // one request in flight: no input while a response waits
    `URRS_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
    // an accepted request is not answered in the next cycle
    `URRS_ASSERT_NEXT(a_not_instant, in_valid && in_ready, !out_valid)
    // a response whose status is not DONE carries no id
    `URRS_ASSERT_IMP(a_id_zero, out_valid && out_data.status != ST_DONE, out_data.selected_id == '0)
    // stalled response holds
    `URRS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind urgency_round_robin_stream_scheduler_top urrs_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
